FILE: rtl/core/differential_fan_controller_core_assert.svh
// Assertion macros shared by the fan controller core.
`ifndef DIFFERENTIAL_FAN_CONTROLLER_CORE_ASSERT_SVH
`define DIFFERENTIAL_FAN_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFC_ASSERT_NOW(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFC_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/core/dfc_pkg.sv
// Shared types and constants for the differential fan controller core.
`default_nettype none

package dfc_pkg;

    localparam int ADC_W   = 10;
    localparam int TEMP_W  = 12;
    localparam int THR_W   = 12;
    localparam int CNT_W   = 3;
    localparam int FUNC_W  = 3;
    localparam int CIDX_W  = 2;

    // Conversion: (adc * -2263 + 1945370) / 1000, truncated toward zero.
    localparam int PROD_W     = 22;
    localparam int MAG_W      = 21;
    localparam int QUOT_W     = 11;
    localparam int SLOPE_MAG  = 2263;
    localparam int OFFSET_NUM = 1945370;
    // floor(m / 1000) == (m * RECIP) >> RECIP_SHIFT for every m below 2**21
    localparam int RECIP       = 2147484;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 31;

    // Reset values of configuration and state.
    localparam logic [THR_W-1:0]  ON_THR_RST  = THR_W'(40);
    localparam logic [THR_W-1:0]  OFF_THR_RST = THR_W'(25);
    localparam logic [CNT_W-1:0]  LIMIT_RST   = CNT_W'(5);
    localparam logic [TEMP_W-1:0] TEMP_RST    = TEMP_W'(200);

    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ       = 3'd0,
        FUNC_FORCE_ON   = 3'd1,
        FUNC_FORCE_OFF  = 3'd2,
        FUNC_SWITCH_ON  = 3'd3,
        FUNC_SWITCH_OFF = 3'd4
    } func_e;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ON_THR  = 2'd0,
        CFG_OFF_THR = 2'd1,
        CFG_LIMIT   = 2'd2
    } cfg_idx_e;

    typedef struct packed {
        logic [THR_W-1:0] on_thr;
        logic [THR_W-1:0] off_thr;
        logic [CNT_W-1:0] limit;
    } cfg_t;

    // Load enables of the three conversion stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

`default_nettype wire

FILE: rtl/core/dfc_lane.sv
// One sensor lane: converts a converter sample to decidegrees in three stages.
`default_nettype none

module dfc_lane (
    input  wire logic                       aclk,
    input  wire dfc_pkg::stage_en_t         en,
    input  wire logic [dfc_pkg::ADC_W-1:0]  adc,
    output dfc_pkg::temp_t                  temp
);
    import dfc_pkg::*;

    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;
    logic [MAG_W-1:0]           mag_reg;
    logic [MAG_W-1:0]           mag_next;
    logic                       neg_reg;
    logic                       neg_next;
    temp_t                      temp_reg;
    temp_t                      temp_next;
    logic signed [PROD_W:0]     num;
    logic signed [PROD_W:0]     num_abs;
    logic [MAG_W+RECIP_W-1:0]   scaled;
    logic [QUOT_W-1:0]          quot;

    // Stage 1: scale the sample by the slope magnitude
    assign prod_next = PROD_W'(adc) * PROD_W'(SLOPE_MAG);

    // Stage 2: add the offset, split into sign and magnitude
    always_comb begin
        num      = (PROD_W+1)'(OFFSET_NUM) - {1'b0, prod_reg};
        num_abs  = num[PROD_W] ? -num : num;
        neg_next = num[PROD_W];
        mag_next = num_abs[MAG_W-1:0];
    end

    // Stage 3: divide the magnitude by 1000 through the reciprocal, restore sign
    always_comb begin
        scaled    = (MAG_W+RECIP_W)'(mag_reg) * (MAG_W+RECIP_W)'(RECIP);
        quot      = scaled[RECIP_SHIFT +: QUOT_W];
        temp_next = neg_reg ? -temp_t'({1'b0, quot}) : temp_t'({1'b0, quot});
    end

    // Advance each stage when its enable is set
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_reg <= prod_next;
        end
        if (en.s2) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (en.s3) begin
            temp_reg <= temp_next;
        end
    end

    assign temp = temp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/dfc_merge.sv
// Merge stage: difference, hysteresis and persistence update, result register.
`default_nettype none

module dfc_merge (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire dfc_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire dfc_pkg::func_e             func,
    input  wire dfc_pkg::temp_t             local_temp,
    input  wire dfc_pkg::temp_t             remote_temp,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output dfc_pkg::temp_t                  m_local_decidegc,
    output dfc_pkg::temp_t                  m_remote_decidegc,
    output logic [dfc_pkg::TEMP_W-1:0]      m_abs_difference,
    output logic                            m_fan_on,
    output logic [dfc_pkg::CNT_W-1:0]       m_persist_count
);
    import dfc_pkg::*;

    // Controller state
    logic                   fan_reg;
    logic                   fan_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    temp_t                  local_reg;
    temp_t                  local_next;
    temp_t                  remote_reg;
    temp_t                  remote_next;
    logic [TEMP_W-1:0]      diff_reg;
    logic [TEMP_W-1:0]      diff_next;
    logic                   valid_reg;

    // Result payload
    temp_t                  out_local_reg;
    temp_t                  out_remote_reg;
    logic [TEMP_W-1:0]      out_diff_reg;
    logic                   out_fan_reg;
    logic [CNT_W-1:0]       out_cnt_reg;

    logic signed [TEMP_W:0] delta;
    logic signed [TEMP_W:0] delta_abs;
    logic [TEMP_W-1:0]      mag;
    logic                   hit_on;
    logic                   hit_off;
    logic                   fan_mid;
    logic [CNT_W-1:0]       cnt_mid;
    logic                   take;

    assign in_ready = !valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // Absolute difference of the incoming temperatures
    always_comb begin
        delta     = {remote_temp[TEMP_W-1], remote_temp} - {local_temp[TEMP_W-1], local_temp};
        delta_abs = delta[TEMP_W] ? -delta : delta;
        mag       = delta_abs[TEMP_W-1:0];
        hit_on    = mag > cfg.on_thr;
        hit_off   = mag < cfg.off_thr;
    end

    // Next state: the on test first, the off test acts on its result
    always_comb begin
        fan_next    = fan_reg;
        cnt_next    = cnt_reg;
        local_next  = local_reg;
        remote_next = remote_reg;
        diff_next   = diff_reg;
        fan_mid     = fan_reg;
        cnt_mid     = cnt_reg;
        unique case (func)
            FUNC_READ: begin
                local_next  = local_temp;
                remote_next = remote_temp;
                diff_next   = mag;
                if (hit_on) begin
                    if (cnt_reg < cfg.limit) begin
                        cnt_mid = cnt_reg + CNT_W'(1);
                    end else begin
                        fan_mid = 1'b1;
                        cnt_mid = '0;
                    end
                end
                fan_next = fan_mid;
                cnt_next = cnt_mid;
                if (hit_off) begin
                    if (cnt_mid < cfg.limit) begin
                        cnt_next = cnt_mid + CNT_W'(1);
                    end else begin
                        fan_next = 1'b0;
                        cnt_next = '0;
                    end
                end
            end
            FUNC_FORCE_ON: begin
                fan_next = 1'b1;
            end
            FUNC_FORCE_OFF: begin
                fan_next = 1'b0;
            end
            FUNC_SWITCH_ON: begin
                fan_next = 1'b1;
                cnt_next = '0;
            end
            FUNC_SWITCH_OFF: begin
                fan_next = 1'b0;
                cnt_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Hold state, update it and load the result on each transfer in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_reg    <= 1'b0;
            cnt_reg    <= '0;
            local_reg  <= temp_t'(TEMP_RST);
            remote_reg <= temp_t'(TEMP_RST);
            diff_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                fan_reg    <= fan_next;
                cnt_reg    <= cnt_next;
                local_reg  <= local_next;
                remote_reg <= remote_next;
                diff_reg   <= diff_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_local_reg  <= local_next;
            out_remote_reg <= remote_next;
            out_diff_reg   <= diff_next;
            out_fan_reg    <= fan_next;
            out_cnt_reg    <= cnt_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_local_decidegc  = out_local_reg;
    assign m_remote_decidegc = out_remote_reg;
    assign m_abs_difference  = out_diff_reg;
    assign m_fan_on          = out_fan_reg;
    assign m_persist_count   = out_cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/core/differential_fan_controller_core.sv
// Top level of the differential fan controller core.
//
// Usage: each transfer on the s_ channel is one item: a reading of two
// sensor samples (s_func read), a force command or a switch event. Every
// item yields exactly one transfer on the m_ channel carrying the stored
// temperatures, their absolute difference, the fan state and the
// persistence counter after the update.
// The first conversion stage loads at the transfer edge; the other two stages and the merge
// stage that holds the controller state follow in turn, each registered. Throughput: one
// item per cycle while the m_ channel does not stall.
// The cfg channel writes on threshold (index 0), off threshold (index 1)
// and persistence limit (index 2); other indexes are dropped. cfg_ready
// is always high. Write it only while no item is in flight.
// Reset (aresetn low, synchronous) empties the pipeline, turns the fan
// off, clears the counter and the difference, sets both temperatures to
// 200 and restores the register defaults (40, 25, 5).
// When the receiver stalls, the result holds on the m_ ports; the stages
// behind it keep filling, and s_ready drops only once all are full.
`default_nettype none

`include "differential_fan_controller_core_assert.svh"

module differential_fan_controller_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dfc_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [dfc_pkg::THR_W-1:0]      cfg_data,
    // Item channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [dfc_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [dfc_pkg::ADC_W-1:0]      s_adc_local,
    input  wire logic [dfc_pkg::ADC_W-1:0]      s_adc_remote,
    // Result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output dfc_pkg::temp_t                      m_local_decidegc,
    output dfc_pkg::temp_t                      m_remote_decidegc,
    output logic [dfc_pkg::TEMP_W-1:0]          m_abs_difference,
    output logic                                m_fan_on,
    output logic [dfc_pkg::CNT_W-1:0]           m_persist_count
);
    import dfc_pkg::*;

    cfg_t       cfg_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    func_e      func1_reg;
    func_e      func2_reg;
    func_e      func3_reg;
    logic       ready1;
    logic       ready2;
    logic       ready3;
    logic       merge_ready;
    stage_en_t  en;
    temp_t      local_temp;
    temp_t      remote_temp;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_thr  <= ON_THR_RST;
            cfg_reg.off_thr <= OFF_THR_RST;
            cfg_reg.limit   <= LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_ON_THR:  cfg_reg.on_thr  <= cfg_data;
                CFG_OFF_THR: cfg_reg.off_thr <= cfg_data;
                CFG_LIMIT:   cfg_reg.limit   <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage handshake: a stage loads when empty or when its successor loads
    assign ready3  = !v3_reg || merge_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;
    assign en.s1   = ready1;
    assign en.s2   = ready2;
    assign en.s3   = ready3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Carry the item code alongside the lanes
    always_ff @(posedge aclk) begin
        if (ready1) begin
            func1_reg <= func_e'(s_func);
        end
        if (ready2) begin
            func2_reg <= func1_reg;
        end
        if (ready3) begin
            func3_reg <= func2_reg;
        end
    end

    dfc_lane u_lane_local (
        .aclk (aclk),
        .en   (en),
        .adc  (s_adc_local),
        .temp (local_temp)
    );

    dfc_lane u_lane_remote (
        .aclk (aclk),
        .en   (en),
        .adc  (s_adc_remote),
        .temp (remote_temp)
    );

    dfc_merge u_merge (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .in_valid          (v3_reg),
        .in_ready          (merge_ready),
        .func              (func3_reg),
        .local_temp        (local_temp),
        .remote_temp       (remote_temp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_local_decidegc  (m_local_decidegc),
        .m_remote_decidegc (m_remote_decidegc),
        .m_abs_difference  (m_abs_difference),
        .m_fan_on          (m_fan_on),
        .m_persist_count   (m_persist_count)
    );

    // An accepted item always lands in the first stage
    `DFC_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_valid && s_ready, v1_reg, "accepted item lost at stage 1")

    // With every stage full and the result stalled, no new transfer is taken
    `DFC_ASSERT_NOW(a_full_blocks_input, aclk, aresetn, v1_reg && v2_reg && v3_reg && m_valid && !m_ready, !s_ready, "input taken while pipeline full")

    // A limit write lands in the register
    `DFC_ASSERT_NEXT(a_limit_write, aclk, aresetn, cfg_valid && cfg_ready && cfg_index == CFG_LIMIT, cfg_reg.limit == $past(cfg_data[CNT_W-1:0]), "persistence limit write lost")

endmodule

`default_nettype wire

FILE: test/dfc_result_checker.sv
// Result checker for the fan controller core: tracks the controller state and compares results.
module dfc_result_checker
    import dfc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [THR_W-1:0]    cfg_data,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic [FUNC_W-1:0]   s_func,
    input  wire logic [ADC_W-1:0]    s_adc_local,
    input  wire logic [ADC_W-1:0]    s_adc_remote,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire temp_t               m_local_decidegc,
    input  wire temp_t               m_remote_decidegc,
    input  wire logic [TEMP_W-1:0]   m_abs_difference,
    input  wire logic                m_fan_on,
    input  wire logic [CNT_W-1:0]    m_persist_count,
    output int                       mismatches,
    output int                       outstanding
);

    // Sensor transfer curve: (adc * SLOPE + OFFSET) / SCALE, truncated toward zero
    localparam int SLOPE  = -2263;
    localparam int OFFSET = 1945370;
    localparam int SCALE  = 1000;

    typedef struct {
        temp_t               loc;
        temp_t               rem;
        logic [TEMP_W-1:0]   diff;
        logic                fan;
        logic [CNT_W-1:0]    cnt;
    } fan_status_t;

    // Controller registers and state as the block should hold them
    logic [THR_W-1:0]   on_thr;
    logic [THR_W-1:0]   off_thr;
    logic [CNT_W-1:0]   limit;
    temp_t              loc_temp;
    temp_t              rem_temp;
    logic [TEMP_W-1:0]  diff_temp;
    logic               fan;
    logic [CNT_W-1:0]   persist;

    fan_status_t        status_q[$];
    fan_status_t        head;

    function automatic temp_t to_tenths(logic [ADC_W-1:0] adc);
        int t;
        t = (int'(adc) * SLOPE + OFFSET) / SCALE;
        return temp_t'(t);
    endfunction

    // Count a qualifying reading, or switch the fan once the limit is reached
    function automatic void qualify(bit hit, logic target);
        if (!hit)
            return;
        if (persist < limit) begin
            persist = persist + 1'b1;
        end else begin
            fan     = target;
            persist = '0;
        end
    endfunction

    function automatic fan_status_t apply_item(logic [FUNC_W-1:0] func,
                                               logic [ADC_W-1:0] adc_l,
                                               logic [ADC_W-1:0] adc_r);
        fan_status_t st;
        int          d;
        case (func)
            FUNC_READ: begin
                loc_temp  = to_tenths(adc_l);
                rem_temp  = to_tenths(adc_r);
                d         = int'(rem_temp) - int'(loc_temp);
                if (d < 0)
                    d = -d;
                diff_temp = d[TEMP_W-1:0];
                // on test first; the off test sees its outcome
                qualify(d > int'(on_thr), 1'b1);
                qualify(d < int'(off_thr), 1'b0);
            end
            FUNC_FORCE_ON:  fan = 1'b1;
            FUNC_FORCE_OFF: fan = 1'b0;
            FUNC_SWITCH_ON: begin
                fan     = 1'b1;
                persist = '0;
            end
            FUNC_SWITCH_OFF: begin
                fan     = 1'b0;
                persist = '0;
            end
            default: ;
        endcase
        st.loc  = loc_temp;
        st.rem  = rem_temp;
        st.diff = diff_temp;
        st.fan  = fan;
        st.cnt  = persist;
        return st;
    endfunction

    task automatic report(string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Follow register writes, check result transfers, predict input transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            on_thr    = ON_THR_RST;
            off_thr   = OFF_THR_RST;
            limit     = LIMIT_RST;
            loc_temp  = TEMP_RST;
            rem_temp  = TEMP_RST;
            diff_temp = '0;
            fan       = 1'b0;
            persist   = '0;
            status_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ON_THR:  on_thr  = cfg_data;
                    CFG_OFF_THR: off_thr = cfg_data;
                    CFG_LIMIT:   limit   = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    report("result transfer with no item outstanding");
                end else begin
                    head = status_q.pop_front();
                    if (m_local_decidegc !== head.loc)
                        report($sformatf("local temperature: got %0d, expected %0d",
                                         m_local_decidegc, head.loc));
                    if (m_remote_decidegc !== head.rem)
                        report($sformatf("remote temperature: got %0d, expected %0d",
                                         m_remote_decidegc, head.rem));
                    if (m_abs_difference !== head.diff)
                        report($sformatf("difference: got %0d, expected %0d",
                                         m_abs_difference, head.diff));
                    if (m_fan_on !== head.fan)
                        report($sformatf("fan state: got %0b, expected %0b",
                                         m_fan_on, head.fan));
                    if (m_persist_count !== head.cnt)
                        report($sformatf("persistence count: got %0d, expected %0d",
                                         m_persist_count, head.cnt));
                end
            end
            if (s_valid && s_ready)
                status_q.push_back(apply_item(s_func, s_adc_local, s_adc_remote));
        end
        outstanding = status_q.size();
    end

endmodule

FILE: test/tb_differential_fan_controller_core.sv
// Testbench top for the fan controller core: clock, reset, stimulus and verdict.
module tb_differential_fan_controller_core;
    import dfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int ADC_TOP     = 1023;

    // Codes the block has no meaning for, and the largest threshold
    localparam logic [CIDX_W-1:0] CFG_SPARE     = CIDX_W'(CFG_LIMIT + 1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_W'(FUNC_SWITCH_OFF + 1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;
    localparam logic [THR_W-1:0]  THR_MAX       = '1;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic [CIDX_W-1:0]   cfg_index    = '0;
    logic [THR_W-1:0]    cfg_data     = '0;
    logic                s_valid      = 1'b0;
    logic [FUNC_W-1:0]   s_func       = '0;
    logic [ADC_W-1:0]    s_adc_local  = '0;
    logic [ADC_W-1:0]    s_adc_remote = '0;
    logic                m_ready      = 1'b0;
    logic                quiet        = 1'b0;

    wire logic                cfg_ready;
    wire logic                s_ready;
    wire logic                m_valid;
    temp_t                    m_local_decidegc;
    temp_t                    m_remote_decidegc;
    wire logic [TEMP_W-1:0]   m_abs_difference;
    wire logic                m_fan_on;
    wire logic [CNT_W-1:0]    m_persist_count;

    int mismatches;
    int outstanding;
    int cycles  = 0;
    int cur_on  = int'(ON_THR_RST);
    int cur_off = int'(OFF_THR_RST);

    differential_fan_controller_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_adc_local       (s_adc_local),
        .s_adc_remote      (s_adc_remote),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_local_decidegc  (m_local_decidegc),
        .m_remote_decidegc (m_remote_decidegc),
        .m_abs_difference  (m_abs_difference),
        .m_fan_on          (m_fan_on),
        .m_persist_count   (m_persist_count)
    );

    dfc_result_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_adc_local       (s_adc_local),
        .s_adc_remote      (s_adc_remote),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_local_decidegc  (m_local_decidegc),
        .m_remote_decidegc (m_remote_decidegc),
        .m_abs_difference  (m_abs_difference),
        .m_fan_on          (m_fan_on),
        .m_persist_count   (m_persist_count),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= !idle_now();
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one item and hold it until the transfer, then maybe idle
    task automatic send_item(logic [FUNC_W-1:0] func, logic [ADC_W-1:0] adc_l,
                             logic [ADC_W-1:0] adc_r);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_adc_local  <= adc_l;
        s_adc_remote <= adc_r;
        do @(posedge aclk); while (!s_ready);
        if (idle_now()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_now());
        end
    endtask

    // Register write; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [THR_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ON_THR:  cur_on  = int'(word);
            CFG_OFF_THR: cur_off = int'(word);
            default: ;
        endcase
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    task automatic configure(int on_val, int off_val, int lim, bit spare);
        logic [THR_W-1:0] word;
        word             = THR_W'($urandom);
        word[CNT_W-1:0]  = CNT_W'(lim);
        write_reg(CFG_ON_THR, THR_W'(on_val));
        write_reg(CFG_OFF_THR, THR_W'(off_val));
        write_reg(CFG_LIMIT, word);
        if (spare)
            write_reg(CFG_SPARE, THR_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Runs of readings aimed near a threshold, with commands mixed in
    task automatic random_phase(int n);
        int left;
        int run;
        int centre;
        int jitter;
        int delta;
        int lo;
        int hi;
        int adc_l;
        bit wide;
        left = n;
        while (left > 0) begin
            run    = $urandom_range(12, 1);
            wide   = ($urandom_range(99) < 20);
            centre = $urandom_range(1) ? cur_on : cur_off;
            repeat (run) begin
                if ($urandom_range(99) < 10) begin
                    send_item(FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_FORCE_ON)),
                              ADC_W'($urandom), ADC_W'($urandom));
                end else if (wide) begin
                    send_item(FUNC_READ, ADC_W'($urandom), ADC_W'($urandom));
                end else begin
                    jitter = $urandom_range(60);
                    delta  = (centre + jitter - 30) * 10 / 23;
                    if (delta < 0)
                        delta = 0;
                    if (delta > ADC_TOP)
                        delta = ADC_TOP;
                    if ($urandom_range(1))
                        delta = -delta;
                    lo    = (delta < 0) ? -delta : 0;
                    hi    = (delta < 0) ? ADC_TOP : ADC_TOP - delta;
                    adc_l = $urandom_range(hi, lo);
                    send_item(FUNC_READ, ADC_W'(adc_l), ADC_W'(adc_l + delta));
                end
                left--;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset temperatures, every command, extremes, both switch-overs
        send_item(FUNC_SPARE_LO, '1, '1);
        send_item(FUNC_FORCE_ON, '0, '0);
        send_item(FUNC_FORCE_OFF, '1, '1);
        send_item(FUNC_SWITCH_ON, '0, '1);
        send_item(FUNC_SWITCH_OFF, '1, '0);
        send_item(FUNC_READ, '0, '0);
        send_item(FUNC_READ, '1, '1);
        send_item(FUNC_READ, '1, '0);
        repeat (7) send_item(FUNC_READ, '0, '1);
        send_item(FUNC_SPARE_HI, '1, '0);
        send_item(FUNC_SPARE_LO + 1'b1, '0, '1);
        repeat (6) send_item(FUNC_READ, 10'd512, 10'd512);
        send_item(FUNC_FORCE_ON, '0, '0);
        send_item(FUNC_SWITCH_OFF, '0, '0);
        random_phase(PHASE_ITEMS);

        // Zero thresholds and zero limit, plus a write to an unused index
        drain();
        configure(0, 0, 0, 1'b1);
        random_phase(PHASE_ITEMS);

        // Largest thresholds and limit
        drain();
        configure(THR_MAX, THR_MAX, 7, 1'b0);
        random_phase(PHASE_ITEMS);

        // Wide band: nothing qualifies
        drain();
        configure(2400, 0, 1, 1'b1);
        random_phase(PHASE_ITEMS);

        // Inverted band: one difference can qualify both ways
        drain();
        configure(10, 100, 2, 1'b0);
        random_phase(PHASE_ITEMS);

        // Reset values, with no idling on either side
        drain();
        quiet <= 1'b1;
        configure(int'(ON_THR_RST), int'(OFF_THR_RST), int'(LIMIT_RST), 1'b0);
        random_phase(PHASE_ITEMS);

        // Random settings
        drain();
        quiet <= 1'b0;
        configure($urandom_range(2400), $urandom_range(2400), $urandom_range(7), 1'b1);
        random_phase(PHASE_ITEMS);
        drain();
        configure($urandom_range(2400), $urandom_range(2400), $urandom_range(7), 1'b0);
        random_phase(PHASE_ITEMS);

        drain();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: differential_fan_controller_core.f
+incdir+rtl/core
rtl/core/dfc_pkg.sv
rtl/core/dfc_lane.sv
rtl/core/dfc_merge.sv
rtl/core/differential_fan_controller_core.sv
test/dfc_result_checker.sv
test/tb_differential_fan_controller_core.sv
